// ===== hdl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and codes for the key-value table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    localparam int KVT_CAPACITY   = 16;
    localparam int KVT_KEY_BITS   = 32;
    localparam int KVT_VALUE_BITS = 32;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] lookup_key;
        logic [31:0] entry_value;
    } kvt_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [3:0]  slot_index;
    } kvt_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/kvt_store.sv =====
// ----------------------------------------------------------------------------
// kvt_store
// Entry storage: key and value arrays, one write port, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_store #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [KEY_W-1:0]         wr_key,
    input  wire logic [VAL_W-1:0]         wr_val,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [KEY_W-1:0]         rd_key,
    output logic      [VAL_W-1:0]         rd_val
);

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0] val_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key <= key_mem[rd_addr];
            rd_val <= val_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/key_value_table_engine.sv =====
// ----------------------------------------------------------------------------
// key_value_table_engine
// Insertion-ordered key-value table: set, get and remove by linear search.
// ----------------------------------------------------------------------------
// Each item scans entries in order until a match or the fill count, then
// decides; a remove then moves each later entry down one slot. Entries
// scanned plus entries moved never pass the fill count. The result strobes
// in the cycle after the last busy state, with busy already low.
// A new item is taken only while busy is low; results cannot stall.
// Reset empties the table (fill count zero); no clearing pass is needed.
`default_nettype none

module key_value_table_engine #(
    parameter int CAPACITY   = kvt_pkg::KVT_CAPACITY,
    parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
    parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kvt_pkg::kvt_req_t req,
    output logic                  rsp_valid,
    output kvt_pkg::kvt_rsp_t     rsp
);

    import kvt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;

    logic [2:0]       state_reg,  state_next;
    logic [CNT_W-1:0] fill_reg,   fill_next;
    logic [IDX_W-1:0] ptr_reg,    ptr_next;
    logic [IDX_W-1:0] slot_reg,   slot_next;
    logic             found_reg,  found_next;
    logic [1:0]       op_reg,     op_next;
    logic [KEY_W-1:0] key_reg,    key_next;
    logic [VAL_W-1:0] val_reg,    val_next;
    logic [VAL_W-1:0] rdval_reg,  rdval_next;
    logic             rsp_valid_reg, rsp_valid_next;
    kvt_rsp_t         rsp_reg,    rsp_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;

    kvt_store #(
        .DEPTH (CAPACITY),
        .KEY_W (KEY_W),
        .VAL_W (VAL_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_val  (wr_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_val  (rd_val)
    );

    function automatic kvt_rsp_t pack_rsp(
        input logic             hit,
        input logic [VAL_W-1:0] value,
        input logic [1:0]       status,
        input logic [CNT_W-1:0] count,
        input logic [IDX_W-1:0] slot
    );
        kvt_rsp_t           r;
        logic [31:0]        v32;
        logic [CNT_W+4:0]   c_wide;
        logic [IDX_W+3:0]   s_wide;
        v32           = '0;
        v32[VAL_W-1:0] = value;
        c_wide        = (CNT_W + 5)'(count);
        s_wide        = (IDX_W + 4)'(slot);
        r.hit         = hit;
        r.read_value  = v32;
        r.status      = status;
        r.entry_count = c_wide[4:0];
        r.slot_index  = s_wide[3:0];
        return r;
    endfunction

    logic             accept;
    logic             key_match;
    logic             scan_last;
    logic             shift_more;
    logic             remove_more;

    assign accept      = start && !busy;
    assign key_match   = (rd_key == key_reg);
    assign scan_last   = ((CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(fill_reg);
    assign remove_more = ((CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(fill_reg);
    assign shift_more  = ((CNT_W + 1)'(ptr_reg) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(fill_reg);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        rdval_next     = rdval_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg;
        wr_key         = key_reg;
        wr_val         = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.op;
                    key_next   = req.lookup_key[KEY_W-1:0];
                    val_next   = req.entry_value[VAL_W-1:0];
                    ptr_next   = '0;
                    found_next = 1'b0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = (fill_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (key_match)
                begin
                    found_next = 1'b1;
                    rdval_next = rd_val;
                    state_next = S_DECIDE;
                end
                else if (scan_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + IDX_W'(1);
                end
            end
            S_DECIDE:
            begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
                case (op_reg)
                    OP_SET:
                    begin
                        if (found_reg)
                        begin
                            wr_en    = 1'b1;
                            rsp_next = pack_rsp(1'b1, '0, ST_DONE, fill_reg, ptr_reg);
                        end
                        else if (fill_reg == CNT_W'(CAPACITY))
                        begin
                            rsp_next = pack_rsp(1'b0, '0, ST_FULL, fill_reg, '0);
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = fill_reg[IDX_W-1:0];
                            fill_next = fill_reg + CNT_W'(1);
                            rsp_next  = pack_rsp(1'b0, '0, ST_DONE, fill_next,
                                                 fill_reg[IDX_W-1:0]);
                        end
                    end
                    OP_GET:
                    begin
                        if (found_reg)
                            rsp_next = pack_rsp(1'b1, rdval_reg, ST_DONE, fill_reg, ptr_reg);
                        else
                            rsp_next = pack_rsp(1'b0, '0, ST_MISS, fill_reg, '0);
                    end
                    OP_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            rsp_next = pack_rsp(1'b0, '0, ST_MISS, fill_reg, '0);
                        end
                        else if (remove_more)
                        begin
                            // close the gap before reporting
                            rsp_valid_next = 1'b0;
                            slot_next      = ptr_reg;
                            rd_en          = 1'b1;
                            rd_addr        = ptr_reg + IDX_W'(1);
                            state_next     = S_SHIFT;
                        end
                        else
                        begin
                            fill_next = fill_reg - CNT_W'(1);
                            rsp_next  = pack_rsp(1'b1, '0, ST_DONE, fill_next, ptr_reg);
                        end
                    end
                    default:
                    begin
                        rsp_next = pack_rsp(1'b0, '0, ST_DONE, fill_reg, '0);
                    end
                endcase
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_key  = rd_key;
                wr_val  = rd_val;
                if (shift_more)
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + IDX_W'(2);
                end
                else
                begin
                    fill_next      = fill_reg - CNT_W'(1);
                    rsp_next       = pack_rsp(1'b1, '0, ST_DONE, fill_next, slot_reg);
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        slot_reg  <= slot_next;
        found_reg <= found_next;
        op_reg    <= op_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        rdval_reg <= rdval_next;
        rsp_reg   <= rsp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_rsp_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ($past(state_reg) == S_DECIDE || $past(state_reg) == S_SHIFT))
        else $error("result strobe without a finished item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == ST_FULL) |-> fill_reg == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.hit) |-> rsp_reg.status == ST_DONE)
        else $error("hit reported with error status");

endmodule

`default_nettype wire

// ===== dv/kvt_checker.sv =====
// ----------------------------------------------------------------------------
// kvt_checker
// Watches the request and reply channels of the key-value table engine. It
// keeps its own copy of the table, works out the reply to each accepted
// request and compares every reply, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------

module kvt_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  kvt_pkg::kvt_req_t req,
    input  logic              rsp_valid,
    input  kvt_pkg::kvt_rsp_t rsp,
    output int                errors,
    output int                owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    logic [KVT_KEY_BITS-1:0]   key_tab [KVT_CAPACITY];
    logic [KVT_VALUE_BITS-1:0] val_tab [KVT_CAPACITY];
    int                        held;
    kvt_rsp_t                  owed_replies [$];
    kvt_rsp_t                  want;
    int                        error_total;

    task automatic report(input string msg);
        error_total++;
        if (error_total <= 40)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Apply one request to the table copy and return the reply it earns.
    function automatic kvt_rsp_t table_request(input kvt_req_t r);
        kvt_rsp_t o;
        int       at;
        o  = '0;
        at = -1;
        for (int i = 0; i < held; i++)
        begin
            if (at < 0 && key_tab[i] == r.lookup_key)
            begin
                at = i;
            end
        end
        case (r.op)
            OP_SET:
            begin
                if (at >= 0)
                begin
                    val_tab[at]  = r.entry_value;
                    o.hit        = 1'b1;
                    o.slot_index = 4'(at);
                end
                else if (held >= KVT_CAPACITY)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    key_tab[held] = r.lookup_key;
                    val_tab[held] = r.entry_value;
                    o.slot_index  = 4'(held);
                    held++;
                end
            end
            OP_GET:
            begin
                if (at >= 0)
                begin
                    o.hit        = 1'b1;
                    o.read_value = val_tab[at];
                    o.slot_index = 4'(at);
                end
                else
                begin
                    o.status = ST_MISS;
                end
            end
            OP_REMOVE:
            begin
                if (at >= 0)
                begin
                    for (int i = at; i + 1 < held; i++)
                    begin
                        key_tab[i] = key_tab[i+1];
                        val_tab[i] = val_tab[i+1];
                    end
                    held--;
                    o.hit        = 1'b1;
                    o.slot_index = 4'(at);
                end
                else
                begin
                    o.status = ST_MISS;
                end
            end
            default:
            begin
            end
        endcase
        o.entry_count = 5'(held);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held        = 0;
            error_total = 0;
            owed_replies.delete();
            errors <= 0;
            owed   <= 0;
        end
        else
        begin
            // reply first: it belongs to an item accepted at an earlier edge
            if (rsp_valid)
            begin
                if (owed_replies.size() == 0)
                begin
                    report("reply with no request outstanding");
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (rsp.hit !== want.hit)
                        report($sformatf("hit: want %0h got %0h", want.hit, rsp.hit));
                    if (rsp.read_value !== want.read_value)
                        report($sformatf("read_value: want %08h got %08h",
                                         want.read_value, rsp.read_value));
                    if (rsp.status !== want.status)
                        report($sformatf("status: want %0h got %0h",
                                         want.status, rsp.status));
                    if (rsp.entry_count !== want.entry_count)
                        report($sformatf("entry_count: want %0d got %0d",
                                         want.entry_count, rsp.entry_count));
                    if (rsp.slot_index !== want.slot_index)
                        report($sformatf("slot_index: want %0d got %0d",
                                         want.slot_index, rsp.slot_index));
                end
            end
            if (start && !busy)
            begin
                owed_replies.push_back(table_request(req));
            end
            errors <= error_total;
            owed   <= owed_replies.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the key-value table engine with a directed run over empty, full and
// boundary cases, then random request mixes over a small key pool that swing
// the table between empty and full. Replies are checked by kvt_checker.
// ----------------------------------------------------------------------------

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kvt_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_REQS = 1700;
    localparam int         POOL_SIZE   = 24;
    localparam int         CYCLE_LIMIT = 1000000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    kvt_req_t req;
    logic     rsp_valid;
    kvt_rsp_t rsp;
    int       reply_errors;
    int       replies_owed;
    int       cycles;

    logic [31:0] key_pool [POOL_SIZE];
    logic [31:0] fill_keys [14];
    bit          no_gaps;

    key_value_table_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    kvt_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .errors    (reply_errors),
        .owed      (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb failed");
        $finish;
    end

    function automatic kvt_req_t make_req(input logic [1:0] op, input logic [31:0] key,
                                          input logic [31:0] value);
        kvt_req_t r;
        r.op          = op;
        r.lookup_key  = key;
        r.entry_value = value;
        return r;
    endfunction

    // Start stays high into the next item when no gap follows.
    task automatic send(input kvt_req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            req   <= make_req(2'($urandom), $urandom, $urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:
            begin
                if (r < 60) return OP_SET;
                if (r < 85) return OP_GET;
                if (r < 96) return OP_REMOVE;
            end
            1:
            begin
                if (r < 20) return OP_SET;
                if (r < 50) return OP_GET;
                if (r < 96) return OP_REMOVE;
            end
            default:
            begin
                if (r < 40) return OP_SET;
                if (r < 70) return OP_GET;
                if (r < 96) return OP_REMOVE;
            end
        endcase
        return OP_UNUSED;
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 82)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'h0;
        if (r < 16) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    initial
    begin
        int mode;
        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        no_gaps = 1'b0;
        mode    = 2;
        for (int i = 0; i < 14; i++)
        begin
            fill_keys[i] = {28'($urandom), 4'(i + 1)};
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = $urandom;
        key_pool[3] = key_pool[2] ^ (32'h1 << $urandom_range(0, 31));
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            key_pool[i] = $urandom;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        send(make_req(OP_GET, 32'h0, 32'h0));
        hold_off(gap_len());
        send(make_req(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        hold_off(gap_len());
        send(make_req(OP_UNUSED, 32'h0, 32'hFFFF_FFFF));
        hold_off(gap_len());
        // extreme keys and values, overwrite
        send(make_req(OP_SET, 32'h0, 32'hFFFF_FFFF));
        send(make_req(OP_SET, 32'hFFFF_FFFF, 32'h0));
        send(make_req(OP_GET, 32'hFFFF_FFFF, 32'h0));
        hold_off(gap_len());
        send(make_req(OP_SET, 32'h0, 32'hA5A5_5A5A));
        send(make_req(OP_GET, 32'h0, 32'hFFFF_FFFF));
        hold_off(gap_len());
        // fill to capacity, then a new key is dropped
        for (int i = 0; i < 14; i++)
        begin
            send(make_req(OP_SET, fill_keys[i], $urandom));
            hold_off(gap_len());
        end
        send(make_req(OP_SET, {28'($urandom) | 28'h1, 4'h0}, $urandom));
        send(make_req(OP_UNUSED, fill_keys[3], $urandom));
        send(make_req(OP_GET, fill_keys[13], 32'h0));
        hold_off(gap_len());
        // remove the first entry (longest shift), then the last
        send(make_req(OP_REMOVE, 32'h0, 32'h0));
        send(make_req(OP_REMOVE, fill_keys[13], 32'h0));
        hold_off(gap_len());

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 60 == 0)
            begin
                mode    = $urandom_range(0, 2);
                no_gaps = ($urandom_range(0, 99) < 25);
            end
            send(make_req(pick_op(mode), pick_key(), pick_value()));
            hold_off(gap_len());
        end

        start <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (reply_errors == 0 && replies_owed == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
